// ===== rtl/core/pdic_pkg.sv =====
package pdic_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = 32;
    localparam int DRIVE_W   = 32;
    localparam int DBAND_W   = SAMPLE_W - 1;
    localparam int LIMIT_W   = SUM_W - 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int ERR_W  = SAMPLE_W + 1;
    localparam int DERR_W = ERR_W + 1;
    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_W;
    localparam int PROD_D_W = GAIN_W + DERR_W;
    localparam int PROD_MAX_W =
        (PROD_I_W > PROD_D_W) ? ((PROD_I_W > PROD_P_W) ? PROD_I_W : PROD_P_W)
                              : ((PROD_D_W > PROD_P_W) ? PROD_D_W : PROD_P_W);
    localparam int ACC_W = PROD_MAX_W + 2;

    // Round half up before the arithmetic shift
    localparam logic [ACC_W-1:0] ACC_HALF =
        (FRAC_BITS > 0) ? ACC_W'(1) << (FRAC_BITS - 1) : '0;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] TARGET_RST = '0;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = '0;
    localparam logic                MODE_RST   = 1'b1;
    localparam logic [DBAND_W-1:0]  DBAND_RST  = DBAND_W'(2 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(500 << FRAC_BITS);

    // Output queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_GAIN_P = 3'd1,
        CFG_GAIN_I = 3'd2,
        CFG_GAIN_D = 3'd3,
        CFG_MODE   = 3'd4,
        CFG_DBAND  = 3'd5,
        CFG_LIMIT  = 3'd6
    } cfg_index_t;

    localparam logic MODE_PLAIN    = 1'b0;
    localparam logic MODE_DEADBAND = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

endpackage

// ===== rtl/core/pdic_out_fifo.sv =====
module pdic_out_fifo import pdic_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_ctl_t               ctl,
    input  logic [DRIVE_W-1:0]   push_data,
    output logic [DRIVE_W-1:0]   head_data,
    output logic                 not_empty,
    output logic [OUT_CNT_W-1:0] count
);

    logic [DRIVE_W-1:0]   mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    logic                 do_pop;

    assign do_pop = ctl.pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = ctl.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(ctl.push) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    // upstream credit must keep the queue from overrunning
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> (count_reg < OUT_CNT_W'(OUT_DEPTH)) || do_pop)
        else $error("output queue overflow");

endmodule

// ===== rtl/core/pid_deadband_integral_clamp.sv =====
// Channel  | handshake               | payload
// ---------+-------------------------+------------------------------------
// input    | s_valid / s_ready       | s_measured   24b signed Q16.8
// result   | m_valid / m_ready       | m_drive      32b signed Q24.8
// config   | cfg_valid / cfg_ready   | cfg_index 3b, cfg_data 32b
//
// One word accepted per cycle while s_ready is high; the error-sum update closes within the integral stage.
// Path from input accept to m_valid: input reg, integral stage,
//   product stage, then rounding/saturation into the output queue.
// Reset (aresetn low, synchronous) restores register defaults, clears the
//   error sum, the previous error, the pipeline and the output queue.
// m_ready low never stalls the pipeline: results collect in an 8-word queue,
//   and s_ready drops once queued plus in-flight words reach 8.
// cfg_ready is always high; write config only while the block is idle.
module pid_deadband_integral_clamp import pdic_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_measured,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DRIVE_W-1:0]    m_drive,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] target_reg;
    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;
    logic                mode_reg;
    logic [DBAND_W-1:0]  dband_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RST;
            gain_p_reg <= GAIN_RST;
            gain_i_reg <= GAIN_RST;
            gain_d_reg <= GAIN_RST;
            mode_reg   <= MODE_RST;
            dband_reg  <= DBAND_RST;
            limit_reg  <= LIMIT_RST;
        end else if (cfg_fire) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET: target_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_GAIN_P: gain_p_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: gain_i_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: gain_d_reg <= cfg_data[GAIN_W-1:0];
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_DBAND:  dband_reg  <= cfg_data[DBAND_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: credit against the output queue
    // ------------------------------------------------------------------
    logic                 in_valid_reg;   // stage 1: sample registered
    logic                 err_valid_reg;  // stage 2: error / sum updated
    logic                 prod_valid_reg; // stage 3: products registered
    logic [OUT_CNT_W-1:0] q_count;
    logic [OUT_CNT_W:0]   credit_used;
    logic                 s_fire;

    assign credit_used = (OUT_CNT_W + 1)'(q_count) + (OUT_CNT_W + 1)'(in_valid_reg)
                       + (OUT_CNT_W + 1)'(err_valid_reg) + (OUT_CNT_W + 1)'(prod_valid_reg);
    assign s_ready = (credit_used < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            err_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= s_fire;
            err_valid_reg  <= in_valid_reg;
            prod_valid_reg <= err_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] meas_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            meas_reg <= s_measured;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: error, deadband, integral update (feedback loop)
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]  prev_err_reg;   // also the P-term operand
    logic signed [DERR_W-1:0] derr_reg;

    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  dband_s;
    logic signed [ERR_W-1:0]  err_eff;
    logic                     in_band;
    logic signed [SUM_W-1:0]  sum_base;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [SUM_W:0]    sum_sat_x;
    logic signed [SUM_W:0]    lim_s;
    logic signed [DERR_W-1:0] derr_next;

    always_comb begin
        err     = $signed({target_reg[SAMPLE_W-1], target_reg})
                - $signed({meas_reg[SAMPLE_W-1], meas_reg});
        dband_s = $signed({2'b00, dband_reg});
        in_band = (mode_reg == MODE_DEADBAND) && (err < dband_s) && (err > -dband_s);
        err_eff  = in_band ? '0 : err;
        sum_base = in_band ? '0 : error_sum_reg;

        // accumulate, saturate to signed 32 bits
        sum_raw = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(err_eff);
        if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
            sum_sat = sum_raw[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                     : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            sum_sat = sum_raw[SUM_W-1:0];
        end

        // symmetric clamp in deadband mode
        sum_sat_x = (SUM_W + 1)'(sum_sat);
        lim_s     = $signed({2'b00, limit_reg});
        error_sum_next = sum_sat;
        if (mode_reg == MODE_DEADBAND) begin
            priority if (sum_sat_x >= lim_s) begin
                error_sum_next = lim_s[SUM_W-1:0];
            end else if (sum_sat_x < -lim_s) begin
                error_sum_next = SUM_W'(-lim_s);
            end
        end

        derr_next = DERR_W'(err_eff) - DERR_W'(prev_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end else if (in_valid_reg) begin
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= err_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg) begin
            derr_reg <= derr_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the three gain products, one multiplier each
    // ------------------------------------------------------------------
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;

    always_ff @(posedge aclk) begin
        if (err_valid_reg) begin
            prod_p_reg <= $signed(gain_p_reg) * prev_err_reg;
            prod_i_reg <= $signed(gain_i_reg) * error_sum_reg;
            prod_d_reg <= $signed(gain_d_reg) * derr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum, round half up, scale, saturate into the queue
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        acc_scaled;
    logic [ACC_W-1:DRIVE_W-1]       acc_top;
    logic [DRIVE_W-1:0]             drive_sat;

    always_comb begin
        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg)
            + $signed(ACC_HALF);
        acc_scaled = acc >>> FRAC_BITS;
        acc_top    = acc_scaled[ACC_W-1:DRIVE_W-1];
        if ((&acc_top) || !(|acc_top)) begin
            drive_sat = acc_scaled[DRIVE_W-1:0];
        end else begin
            drive_sat = acc_top[ACC_W-1] ? {1'b1, {(DRIVE_W - 1){1'b0}}}
                                         : {1'b0, {(DRIVE_W - 1){1'b1}}};
        end
    end

    q_ctl_t q_ctl;

    assign q_ctl.push = prod_valid_reg;
    assign q_ctl.pop  = m_ready;

    pdic_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (q_ctl),
        .push_data (drive_sat),
        .head_data (m_drive),
        .not_empty (m_valid),
        .count     (q_count)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // queued plus in-flight words never exceed the queue depth
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_used <= (OUT_CNT_W + 1)'(OUT_DEPTH))
        else $error("credit bound exceeded");

    // in deadband mode the updated sum stays within +/- limit
    a_sum_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (mode_reg == MODE_DEADBAND) && !cfg_fire)
        |=> ((SUM_W + 1)'(error_sum_reg) <= lim_s)
            && ((SUM_W + 1)'(error_sum_reg) >= -lim_s))
        else $error("error sum escaped clamp");

    // an error inside the band leaves zero as the previous error
    a_band_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_band) |=> (prev_err_reg == '0))
        else $error("deadband error not zeroed");

    // every accepted word reaches the queue through the input, error and product registers
    a_push_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> ##3 q_ctl.push)
        else $error("pipeline lost a word");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pdic_pkg::*;

    localparam int LAT_CYCLES  = 3;        // pipeline drain allowance used by wait_idle
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off, fills the 8-word queue
    localparam longint CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;   // no register behind this index
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint ROUND_HALF = (FRAC_BITS > 0) ? (64'sd1 <<< (FRAC_BITS - 1)) : 64'sd0;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;

    // Clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // Block ports, the inputs at known values from time zero
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_measured = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DRIVE_W-1:0]    m_drive;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pid_deadband_integral_clamp u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Samples waiting to be offered, and drive words still owed by the block
    logic [SAMPLE_W-1:0] measured_q[$];
    logic [DRIVE_W-1:0]  drive_q[$];

    // Controller copy: configuration and loop state as the block should hold them
    logic signed [SAMPLE_W-1:0] set_point;
    logic signed [GAIN_W-1:0]   kp, ki, kd;
    logic                       ctl_mode;
    logic [DBAND_W-1:0]         band;
    logic [LIMIT_W-1:0]         sum_limit;
    longint                     err_sum;
    longint                     last_err;

    // Handshake bookkeeping shared between the clocked processes
    logic   in_fire = 1'b0;       // input word taken at the last rising edge
    logic   idle_on = 1'b1;       // random idle bursts allowed
    logic   hold_req = 1'b0;      // ask the receiver for one long hold-off
    int     tx_gap = 0;
    int     rx_gap = 0;
    int     hold_left = 0;
    int     errors = 0;
    longint cycle_count = 0;
    logic [DRIVE_W-1:0] want;

    function automatic longint clip32(input longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    // One control step: updates the error sum and last error, returns the drive word
    function automatic logic [DRIVE_W-1:0] pid_drive(input logic [SAMPLE_W-1:0] meas);
        longint e;
        longint acc;
        longint lim_v;
        longint db_v;
        e = longint'(set_point) - longint'($signed(meas));
        if (ctl_mode == MODE_DEADBAND) begin
            // error strictly inside the band reads as zero and restarts the sum
            db_v = longint'(band);
            if (e < db_v && e > -db_v) begin
                e = 0;
                err_sum = 0;
            end
            err_sum = clip32(err_sum + e);
            lim_v = longint'(sum_limit);
            if (err_sum >= lim_v) begin
                err_sum = lim_v;
            end else if (err_sum < -lim_v) begin
                err_sum = -lim_v;
            end
        end else begin
            err_sum = clip32(err_sum + e);
        end
        acc = longint'(kp) * e + longint'(ki) * err_sum + longint'(kd) * (e - last_err);
        last_err = e;
        // round half up, then an arithmetic (flooring) shift back to Q.8
        acc = acc + ROUND_HALF;
        return DRIVE_W'(clip32(acc >>> FRAC_BITS));
    endfunction

    // Sample generator: biased toward the band edges and the range extremes
    function automatic logic [SAMPLE_W-1:0] pick_measured();
        int     kind;
        longint w;
        longint off;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            return SAMPLE_W'($urandom);
        end else if (kind <= 5) begin
            w = longint'(band) + 4;
            if (w > 65536) w = 65536;
            off = longint'($urandom_range(0, int'(2 * w))) - w;
            return SAMPLE_W'(longint'(set_point) - off);
        end else if (kind == 6) begin
            return SAMPLE_MAX;
        end else if (kind == 7) begin
            return SAMPLE_MIN;
        end
        off = longint'($urandom_range(0, 8192)) - 4096;
        return SAMPLE_W'(longint'(set_point) + off);
    endfunction

    // Timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor: tracks config writes, checks drive words, predicts each accepted sample.
    // Result check comes before the push, so a word is never compared with its own prediction.
    always @(posedge aclk) begin
        in_fire = aresetn && s_valid && s_ready;
        if (!aresetn) begin
            set_point = '0;
            kp = '0;
            ki = '0;
            kd = '0;
            ctl_mode = MODE_DEADBAND;
            band = DBAND_W'(2 << FRAC_BITS);
            sum_limit = LIMIT_W'(500 << FRAC_BITS);
            err_sum = 0;
            last_err = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                // bits above each register's width are dropped, unknown indexes ignored
                case (cfg_index)
                    CFG_TARGET: set_point = cfg_data[SAMPLE_W-1:0];
                    CFG_GAIN_P: kp = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I: ki = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D: kd = cfg_data[GAIN_W-1:0];
                    CFG_MODE:   ctl_mode = cfg_data[0];
                    CFG_DBAND:  band = cfg_data[DBAND_W-1:0];
                    CFG_LIMIT:  sum_limit = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: drive word with none expected, expected none actual %0d",
                                 $time, $signed(m_drive));
                end else begin
                    want = drive_q.pop_front();
                    if (m_drive !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: drive mismatch, expected %0d actual %0d",
                                     $time, $signed(want), $signed(m_drive));
                    end
                end
            end
            if (in_fire)
                drive_q.push_back(pid_drive(s_measured));
        end
    end

    // Sender: offers the next sample at the falling edge, holds it until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                s_valid <= 1'b0;
            end else if (measured_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                tx_gap = $urandom_range(1, 19) - 1;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_measured <= measured_q.pop_front();
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
            rx_gap = $urandom_range(1, 19) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Config word: one write, held until the handshake completes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Register write with junk above the register's width
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int width,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        mask = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1);
        cfg_write(idx, (CFG_DATA_W'($urandom) & ~mask) | (value & mask));
    endtask

    task automatic program_all(input logic [31:0] t, p, i, d, m, db, lim);
        write_reg(CFG_TARGET, SAMPLE_W, t);
        write_reg(CFG_GAIN_P, GAIN_W, p);
        write_reg(CFG_GAIN_I, GAIN_W, i);
        write_reg(CFG_GAIN_D, GAIN_W, d);
        write_reg(CFG_MODE, 1, m);
        write_reg(CFG_DBAND, DBAND_W, db);
        write_reg(CFG_LIMIT, LIMIT_W, lim);
    endtask

    task automatic program_random();
        program_all($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22));
    endtask

    task automatic push_random(input int n);
        @(posedge aclk);
        repeat (n) measured_q.push_back(pick_measured());
    endtask

    task automatic push_fixed(input logic [SAMPLE_W-1:0] v, input int n);
        @(posedge aclk);
        repeat (n) measured_q.push_back(v);
    endtask

    // Block idle: nothing to offer, nothing owed, pipeline drained
    task automatic wait_idle();
        while (measured_q.size() != 0 || s_valid || drive_q.size() != 0) @(posedge aclk);
        repeat (LAT_CYCLES + 4) @(posedge aclk);
    endtask

    int dir_a[10] = '{0, 511, -511, 512, -512, 8388607, -8388608, 1000, -1000, 0};

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: zero gains, but the sum still moves under the deadband rules
        measured_q.push_back(SAMPLE_W'(0));
        measured_q.push_back(SAMPLE_W'(2000));
        measured_q.push_back(SAMPLE_MIN);
        wait_idle();

        // Band edges (one LSB inside and exactly on the edge) and range extremes
        program_all(0, 256, 16, 64, MODE_DEADBAND, 512, 128000);
        @(posedge aclk);
        foreach (dir_a[k]) measured_q.push_back(SAMPLE_W'(dir_a[k]));
        wait_idle();

        // Unknown index is dropped; plain mode ignores the band
        cfg_write(CFG_UNUSED, $urandom);
        write_reg(CFG_MODE, 1, MODE_PLAIN);
        @(posedge aclk);
        measured_q.push_back(SAMPLE_W'(300));
        measured_q.push_back(SAMPLE_W'(-300));
        measured_q.push_back(SAMPLE_MAX);
        wait_idle();

        // Mid-range random settings
        program_random();
        write_reg(CFG_MODE, 1, MODE_DEADBAND);
        push_random(150);
        wait_idle();

        // Plain mode, full-scale error on each fixed word: sum and drive both saturate
        program_all({8'h00, SAMPLE_MAX}, 32'h7FFF, 32'h7FFF, 32'h8000, MODE_PLAIN,
                    $urandom, $urandom);
        push_fixed(SAMPLE_MIN, 140);
        push_random(20);
        wait_idle();

        // Zero band and zero limit; long receiver hold-off while samples keep coming
        program_all($urandom, $urandom, $urandom, $urandom, MODE_DEADBAND, 0, 0);
        @(posedge aclk);
        hold_req = 1'b1;
        push_random(80);
        wait_idle();

        // Widest limit, most negative target, extreme gains
        program_all({8'h00, SAMPLE_MIN}, 32'h8000, 32'h8000, 32'h7FFF, MODE_DEADBAND,
                    0, 32'h7FFF_FFFF);
        push_fixed(SAMPLE_MAX, 40);
        push_random(40);
        wait_idle();

        // Widest band: almost every error reads as zero
        program_all($urandom, $urandom, $urandom, $urandom, MODE_DEADBAND,
                    32'h007F_FFFF, $urandom);
        push_random(40);
        wait_idle();

        repeat (3) begin
            program_random();
            push_random(60);
            wait_idle();
        end

        // Last stretch at full rate on both sides
        idle_on = 1'b0;
        program_random();
        push_random(80);
        wait_idle();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
